[hdl/dkci_pkg.sv]
// Shared types and constants of the keyframe color interpolator.
package dkci_pkg;

	localparam int TIME_W      = 17;
	localparam int VAL_W       = 8;
	localparam int CHANNELS    = 4;
	localparam int SLOT_W      = 3;
	localparam int KEYS_W      = 4;
	localparam int PCT_W       = 7;
	localparam int SPAN_W      = 19;
	localparam int DAY_SECONDS = 86400;
	localparam int PERCENT     = 100;
	localparam int RECIP_100   = 5243;
	localparam int RECIP_SHIFT = 19;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_EVAL  = 1'b1
	} op_t;

	typedef struct packed {
		logic [TIME_W-1:0]                  time_s;
		logic [CHANNELS-1:0][VAL_W-1:0]     val;
	} keyframe_t;

	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] key_index;
		logic [TIME_W-1:0] key_time;
		logic [VAL_W-1:0]  key_brightness;
		logic [VAL_W-1:0]  key_red;
		logic [VAL_W-1:0]  key_green;
		logic [VAL_W-1:0]  key_blue;
		logic [TIME_W-1:0] now_seconds;
	} item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] last_key;
		logic [PCT_W-1:0]  progress_percent;
		logic [VAL_W-1:0]  bright_out;
		logic [VAL_W-1:0]  red_out;
		logic [VAL_W-1:0]  green_out;
		logic [VAL_W-1:0]  blue_out;
	} result_t;

endpackage

[hdl/dkci_ifs.sv]
// Handshake channel interfaces: input items, results, register writes.
interface dkci_item_if;
	logic           valid;
	logic           ready;
	dkci_pkg::item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface dkci_result_if;
	logic              valid;
	logic              ready;
	dkci_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface dkci_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [dkci_pkg::KEYS_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[hdl/daily_keyframe_color_interpolator.sv]
// Top level of the daily keyframe color interpolator: sequencer and shared datapath.
//
//   channel  dir  word      purpose
//   item     in   item_t    keyframe write or evaluate request
//   result   out  result_t  chosen key, progress, interpolated channels
//   cfg      in   4 bits    keys_in_use
//
// A write word is stored in the table as it is accepted. An evaluate word
// scans n keys (n = keys in use), one table read per cycle, then eight
// restoring-divide steps give the percentage; S_CMUL, S_CDIV run per channel.
// Reset is asynchronous; the table is not cleared. A result waiting in the
// output register does not block the next word, only the next result.
module daily_keyframe_color_interpolator #(
	parameter int MAX_KEYS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	dkci_item_if.sink     item,
	dkci_result_if.source result,
	dkci_cfg_if.sink      cfg
);
	import dkci_pkg::*;

	localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CNT_W = $clog2(MAX_KEYS + 1);
	localparam int MAG_W = SPAN_W - 1;
	localparam int DIV_W = MAG_W + 7;
	localparam int PRD_W = VAL_W + PCT_W;
	localparam int SCL_W = PRD_W + 13;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_SCAN  = 11'b00000000010,
		S_PICK  = 11'b00000000100,
		S_FLAST = 11'b00000001000,
		S_FNEXT = 11'b00000010000,
		S_SETUP = 11'b00000100000,
		S_DIV   = 11'b00001000000,
		S_FIX   = 11'b00010000000,
		S_CMUL  = 11'b00100000000,
		S_CDIV  = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

	state_t                        state_q;
	logic                          out_valid_q;
	logic [KEYS_W-1:0]             keys_q;
	result_t                       out_q;

	logic [TIME_W-1:0]             now_q;
	logic [IDX_W-1:0]              n_m1_q;
	logic [IDX_W-1:0]              cnt_q;
	logic [IDX_W-1:0]              last_q;
	logic [IDX_W-1:0]              next_q;
	logic                          found_q;
	logic                          wrap_q;
	logic [TIME_W-1:0]             t_last_q;
	logic [CHANNELS-1:0][VAL_W-1:0] a_q;
	logic [CHANNELS-1:0][VAL_W-1:0] b_q;
	logic [CHANNELS-1:0][VAL_W-1:0] v_q;
	logic signed [SPAN_W-1:0]      elap_q;
	logic signed [SPAN_W-1:0]      dist_q;
	logic                          pzero_q;
	logic [DIV_W-1:0]              rem_q;
	logic [DIV_W-1:0]              den_q;
	logic [7:0]                    quo_q;
	logic [2:0]                    step_q;
	logic [PCT_W-1:0]              p_q;
	logic [1:0]                    ch_q;
	logic                          neg_q;
	logic [PRD_W-1:0]              prod_q;

	logic                          in_acc;
	logic                          out_load;
	logic [CNT_W-1:0]              n_c;
	logic [IDX_W-1:0]              sel_c;
	logic [IDX_W-1:0]              rd_addr;
	keyframe_t                     rd_data;
	keyframe_t                     wr_data;
	logic                          wr_en;
	logic signed [SPAN_W-1:0]      elap_c;
	logic signed [SPAN_W-1:0]      dist_c;
	logic [MAG_W-1:0]              elap_mag;
	logic [MAG_W-1:0]              dist_mag;
	logic signed [VAL_W:0]         diff_c;
	logic [VAL_W-1:0]              diff_mag;
	logic [SCL_W-1:0]              scaled_c;
	logic [VAL_W-1:0]              qv_c;

	assign in_acc   = item.valid && item.ready;
	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || result.ready);
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	assign wr_en = in_acc && (item.data.op == OP_WRITE) &&
		(32'(item.data.key_index) < MAX_KEYS);
	assign wr_data.time_s = item.data.key_time;
	assign wr_data.val    = {item.data.key_blue, item.data.key_green,
		item.data.key_red, item.data.key_brightness};

	always_comb begin
		if (keys_q == '0) begin
			n_c = CNT_W'(1);
		end else if (32'(keys_q) > MAX_KEYS) begin
			n_c = CNT_W'(MAX_KEYS);
		end else begin
			n_c = CNT_W'(keys_q);
		end
	end

	assign sel_c = found_q ? last_q : n_m1_q;

	always_comb begin
		case (state_q)
			S_SCAN:  rd_addr = cnt_q + 1'b1;
			S_PICK:  rd_addr = sel_c;
			S_FLAST: rd_addr = next_q;
			default: rd_addr = '0;
		endcase
	end

	dkci_kf_mem #(
		.DEPTH (MAX_KEYS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (IDX_W'(item.data.key_index)),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_comb begin
		elap_c = $signed({2'b00, now_q}) - $signed({2'b00, rd_data.time_s});
		if (now_q < rd_data.time_s) begin
			elap_c = elap_c + SPAN_W'(DAY_SECONDS);
		end
		dist_c = $signed({2'b00, rd_data.time_s}) - $signed({2'b00, t_last_q});
		if (wrap_q) begin
			dist_c = dist_c + SPAN_W'(DAY_SECONDS);
		end
	end

	assign elap_mag = elap_q[SPAN_W-1] ? MAG_W'(-elap_q) : MAG_W'(elap_q);
	assign dist_mag = dist_q[SPAN_W-1] ? MAG_W'(-dist_q) : MAG_W'(dist_q);

	assign diff_c   = $signed({1'b0, b_q[ch_q]}) - $signed({1'b0, a_q[ch_q]});
	assign diff_mag = diff_c[VAL_W] ? VAL_W'(-diff_c) : VAL_W'(diff_c);
	assign scaled_c = SCL_W'(prod_q) * SCL_W'(RECIP_100);
	assign qv_c     = scaled_c[RECIP_SHIFT +: VAL_W];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			keys_q      <= KEYS_W'(6);
		end else begin
			if (cfg.valid) begin
				keys_q <= cfg.data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && item.data.op == OP_EVAL) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cnt_q == n_m1_q) begin
						state_q <= S_PICK;
					end
				end
				S_PICK:  state_q <= S_FLAST;
				S_FLAST: state_q <= S_FNEXT;
				S_FNEXT: state_q <= S_SETUP;
				S_SETUP: state_q <= S_DIV;
				S_DIV: begin
					if (step_q == '0) begin
						state_q <= S_FIX;
					end
				end
				S_FIX:   state_q <= S_CMUL;
				S_CMUL:  state_q <= S_CDIV;
				S_CDIV: begin
					state_q <= (ch_q == 2'(CHANNELS - 1)) ? S_DONE : S_CMUL;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				now_q   <= item.data.now_seconds;
				n_m1_q  <= IDX_W'(n_c - 1'b1);
				cnt_q   <= '0;
				found_q <= 1'b0;
				last_q  <= '0;
			end
			S_SCAN: begin
				if ({2'b00, now_q} > {2'b00, rd_data.time_s}) begin
					last_q  <= cnt_q;
					found_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
			S_PICK: begin
				last_q <= sel_c;
				wrap_q <= (sel_c == n_m1_q);
				next_q <= (sel_c == n_m1_q) ? '0 : sel_c + 1'b1;
			end
			S_FLAST: begin
				t_last_q <= rd_data.time_s;
				a_q      <= rd_data.val;
				elap_q   <= elap_c;
			end
			S_FNEXT: begin
				b_q    <= rd_data.val;
				dist_q <= dist_c;
			end
			S_SETUP: begin
				pzero_q <= (dist_q == '0) || (elap_q == '0) ||
					(elap_q[SPAN_W-1] != dist_q[SPAN_W-1]);
				rem_q   <= DIV_W'(elap_mag) * DIV_W'(PERCENT);
				den_q   <= {dist_mag, 7'b0};
				quo_q   <= '0;
				step_q  <= 3'd7;
			end
			S_DIV: begin
				if (rem_q >= den_q) begin
					rem_q <= rem_q - den_q;
					quo_q <= {quo_q[6:0], 1'b1};
				end else begin
					quo_q <= {quo_q[6:0], 1'b0};
				end
				den_q  <= den_q >> 1;
				step_q <= step_q - 1'b1;
			end
			S_FIX: begin
				if (pzero_q) begin
					p_q <= '0;
				end else if (quo_q[7] || quo_q[6:0] > PCT_W'(PERCENT)) begin
					p_q <= PCT_W'(PERCENT);
				end else begin
					p_q <= quo_q[6:0];
				end
				ch_q <= '0;
			end
			S_CMUL: begin
				neg_q  <= diff_c[VAL_W];
				prod_q <= PRD_W'(p_q) * PRD_W'(diff_mag);
			end
			S_CDIV: begin
				v_q[ch_q] <= neg_q ? a_q[ch_q] - qv_c : a_q[ch_q] + qv_c;
				ch_q      <= ch_q + 1'b1;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q.last_key         <= SLOT_W'(last_q);
			out_q.progress_percent <= p_q;
			out_q.bright_out       <= v_q[0];
			out_q.red_out          <= v_q[1];
			out_q.green_out        <= v_q[2];
			out_q.blue_out         <= v_q[3];
		end
	end

endmodule

[hdl/dkci_kf_mem.sv]
// Keyframe table: one write port, one registered read port.
module dkci_kf_mem #(
	parameter int DEPTH = 8,
	parameter int IDX_W = 3
) (
	input  logic                clk,
	input  logic                we,
	input  logic [IDX_W-1:0]    waddr,
	input  dkci_pkg::keyframe_t wdata,
	input  logic [IDX_W-1:0]    raddr,
	output dkci_pkg::keyframe_t rdata
);
	import dkci_pkg::*;

	keyframe_t mem_q [DEPTH];
	keyframe_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
